### rtl/trle_pkg.sv
package trle_pkg;

  // run length field width, fixed by the coded byte format
  localparam int unsigned LEN_W = 7;

  // byte that marks a transparent run and ends every row
  localparam logic [7:0] CLEAR_MARK = 8'h80;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_TMARK = 6'b000010,
    ST_LEN   = 6'b000100,
    ST_LIT   = 6'b001000,
    ST_PLACE = 6'b010000,
    ST_MARK  = 6'b100000
  } trle_state_t;

endpackage

### rtl/transparent_run_length_encoder_unit.sv
// Sequence: a pixel that opens or extends a run is accepted, then stored.
// A pixel closing an opaque run waits for its length byte and literals, a transparent
// one for its mark byte; at row end an open opaque run is sent before the final mark.
// Bytes leave one per cycle (one literal memory read port) unless out_stall holds a word.
// No pixel is taken until the last is stored; words hold 8 bytes, fewer at burst end.
// Reset: run state, sequencer and output valid clear; the literal memory is not cleared.
module transparent_run_length_encoder_unit #(
  parameter int unsigned MAX_RUN = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel,
  input  logic        in_row_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_packed_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_last_of_burst
);

  localparam int unsigned LW = trle_pkg::LEN_W;
  localparam int unsigned AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  trle_pkg::trle_state_t state_r, state_nxt;

  logic          run_open_r, run_open_nxt;
  logic          run_clear_r, run_clear_nxt;
  logic [LW-1:0] run_len_r, run_len_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic          fin_r, fin_nxt;
  logic [7:0]    px_r;
  logic          clear_r;
  logic          end_r;

  logic [7:0]    mem [MAX_RUN];
  logic [7:0]    rd_data_r;
  logic          rd_en;
  logic [LW-1:0] rd_addr;
  logic          mem_we;
  logic [LW-1:0] wr_addr;

  logic [63:0]   word_r;
  logic [2:0]    fill_r;
  logic [63:0]   lane_word;

  logic          out_valid_r;
  logic [63:0]   out_bytes_r;
  logic [3:0]    out_count_r;
  logic          out_last_r;

  logic          accept;
  logic          in_clear;
  logic          close_old;
  logic          emit;
  logic [7:0]    emit_byte;
  logic          emit_last;
  logic          push;
  logic          adv;
  logic          lit_last;

  // input side
  assign in_stall  = (state_r != trle_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_clear  = (in_pixel == 8'd0);
  assign close_old = run_open_r &&
                     ((in_clear != run_clear_r) || (run_len_r >= LW'(MAX_RUN)));
  assign lit_last  = (({1'b0, idx_r} + 8'd1) == {1'b0, run_len_r});

  // byte source
  always_comb begin
    emit      = 1'b0;
    emit_byte = 8'd0;
    emit_last = 1'b0;
    case (state_r)
      trle_pkg::ST_TMARK: begin
        emit      = 1'b1;
        emit_byte = trle_pkg::CLEAR_MARK | {1'b0, run_len_r};
        emit_last = !end_r;
      end
      trle_pkg::ST_LEN: begin
        emit      = 1'b1;
        emit_byte = {1'b0, run_len_r};
      end
      trle_pkg::ST_LIT: begin
        emit      = 1'b1;
        emit_byte = rd_data_r;
        emit_last = !end_r && lit_last;
      end
      trle_pkg::ST_MARK: begin
        emit      = 1'b1;
        emit_byte = trle_pkg::CLEAR_MARK;
        emit_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // a byte moves on unless it completes a word that cannot leave
  assign push = emit && ((fill_r == 3'd7) || emit_last);
  assign adv  = emit && (!push || !out_valid_r || !out_stall);

  // literal memory ports
  assign rd_en   = adv && ((state_r == trle_pkg::ST_LEN) ||
                           ((state_r == trle_pkg::ST_LIT) && !lit_last));
  assign rd_addr = (state_r == trle_pkg::ST_LEN) ? '0 : idx_r + 1'b1;
  assign mem_we  = (state_r == trle_pkg::ST_PLACE) && !clear_r;
  assign wr_addr = run_open_r ? run_len_r : '0;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    run_open_nxt  = run_open_r;
    run_clear_nxt = run_clear_r;
    run_len_nxt   = run_len_r;
    idx_nxt       = idx_r;
    fin_nxt       = fin_r;
    case (state_r)
      trle_pkg::ST_IDLE: begin
        if (accept) begin
          fin_nxt = 1'b0;
          if (!close_old) begin
            state_nxt = trle_pkg::ST_PLACE;
          end else if (run_clear_r) begin
            state_nxt = trle_pkg::ST_TMARK;
          end else begin
            state_nxt = trle_pkg::ST_LEN;
          end
        end
      end
      trle_pkg::ST_TMARK: begin
        if (adv) begin
          state_nxt     = trle_pkg::ST_PLACE;
          run_open_nxt  = 1'b0;
          run_clear_nxt = 1'b0;
          run_len_nxt   = '0;
        end
      end
      trle_pkg::ST_LEN: begin
        if (adv) begin
          state_nxt = trle_pkg::ST_LIT;
          idx_nxt   = '0;
        end
      end
      trle_pkg::ST_LIT: begin
        if (adv) begin
          if (!lit_last) begin
            idx_nxt = idx_r + 1'b1;
          end else if (fin_r) begin
            state_nxt = trle_pkg::ST_MARK;
          end else begin
            state_nxt     = trle_pkg::ST_PLACE;
            run_open_nxt  = 1'b0;
            run_clear_nxt = 1'b0;
            run_len_nxt   = '0;
          end
        end
      end
      trle_pkg::ST_PLACE: begin
        // open a run or extend the open one with the held pixel
        run_open_nxt = 1'b1;
        if (!run_open_r) begin
          run_clear_nxt = clear_r;
          run_len_nxt   = LW'(1);
        end else begin
          run_len_nxt = run_len_r + 1'b1;
        end
        if (end_r) begin
          fin_nxt   = 1'b1;
          state_nxt = (!run_open_r ? clear_r : run_clear_r) ?
                      trle_pkg::ST_MARK : trle_pkg::ST_LEN;
        end else begin
          state_nxt = trle_pkg::ST_IDLE;
        end
      end
      trle_pkg::ST_MARK: begin
        if (adv) begin
          state_nxt     = trle_pkg::ST_IDLE;
          run_open_nxt  = 1'b0;
          run_clear_nxt = 1'b0;
          run_len_nxt   = '0;
          fin_nxt       = 1'b0;
        end
      end
      default: begin
        state_nxt = trle_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= trle_pkg::ST_IDLE;
      run_open_r  <= 1'b0;
      run_clear_r <= 1'b0;
      run_len_r   <= '0;
      idx_r       <= '0;
      fin_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_open_r  <= run_open_nxt;
      run_clear_r <= run_clear_nxt;
      run_len_r   <= run_len_nxt;
      idx_r       <= idx_nxt;
      fin_r       <= fin_nxt;
    end
  end

  // held input beat
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r    <= in_pixel;
      clear_r <= in_clear;
      end_r   <= in_row_end;
    end
  end

  // literal memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(wr_addr)] <= px_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[AW'(rd_addr)];
    end
  end

  // byte packer
  always_comb begin
    lane_word = word_r;
    lane_word[{fill_r, 3'b000} +: 8] = emit_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
      fill_r <= '0;
    end else if (adv) begin
      if (push) begin
        word_r <= '0;
        fill_r <= '0;
      end else begin
        word_r <= lane_word;
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && push) begin
      out_bytes_r <= lane_word;
      out_count_r <= {1'b0, fill_r} + 4'd1;
      out_last_r  <= emit_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_packed_bytes  = out_bytes_r;
  assign out_byte_count    = out_count_r;
  assign out_last_of_burst = out_last_r;

  // checks
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_len_r <= LW'(MAX_RUN))
    else $error("run length beyond limit");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_count_r == 4'd8)
    else $error("short word before end of burst");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_count_r != 4'd0 && out_count_r <= 4'd8)
    else $error("byte count out of range");

  a_lit_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == trle_pkg::ST_LIT |-> idx_r < run_len_r)
    else $error("literal index past run");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != trle_pkg::ST_IDLE)
    else $error("accepted beat not processed");

endmodule
